[hdl/gda_pkg.sv]
// shared types, codes and calendar functions of the gregorian date adder
package gda_pkg;

  localparam int unsigned RemW   = 16;   // day count register, holds up to 33133
  localparam int unsigned YearW  = 15;   // working year, start year plus the walk
  localparam int unsigned ModW   = 9;    // year mod 400

  localparam logic [RemW-1:0]  YearCycle = 16'd400;
  localparam logic [YearW-1:0] YearMax   = 15'd9999;
  localparam logic [ModW-1:0]  ModLast   = 9'd399;

  localparam logic [3:0] MonJan = 4'd1;
  localparam logic [3:0] MonFeb = 4'd2;
  localparam logic [3:0] MonDec = 4'd12;

  typedef enum logic {
    AluAdd = 1'b0,
    AluSub = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e         op;
    logic [RemW-1:0] a;
    logic [RemW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [RemW-1:0] res;
    logic            ge;   // a >= b
    logic            le;   // a <= b
  } alu_rsp_t;

  // leap test from the year mod 400
  function automatic logic is_leap(input logic [ModW-1:0] ymod);
    logic century;
    century = (ymod == 9'd100) || (ymod == 9'd200) || (ymod == 9'd300);
    return (ymod == '0) || ((ymod[1:0] == 2'b00) && !century);
  endfunction

  // month length, month in 1..12
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      MonFeb:                                    len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[hdl/gregorian_date_add_days_core.sv]
// top level of the gregorian date adder: sequencer around the shared alu
//
//   channel  direction  handshake                 beat contents
//   in       sink       in_valid_i / in_stall_o   start_day, start_month, start_year, days_to_add
//   out      source     out_valid_o / out_stall_i result_day, result_month, result_year,
//                                                 year_overflow
//
// one beat passes through the year mod 400 reduction, the sum of the months before the
// start month and the month walk from january; at worst the month walk through the
// single shared alu is by far the longest part
// reset clears the sequencer and the output valid, nothing else
// in_stall_o is high from accept until the result is loaded into the output register
// a new beat is taken while a finished result still waits on out_stall_i
module gregorian_date_add_days_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  start_day_i,
  input  logic [3:0]  start_month_i,
  input  logic [13:0] start_year_i,
  input  logic [14:0] days_to_add_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  result_day_o,
  output logic [3:0]  result_month_o,
  output logic [13:0] result_year_o,
  output logic        year_overflow_o
);

  // sequencer codes
  localparam logic [2:0] StIdle   = 3'd0;  // waiting for a beat
  localparam logic [2:0] StMod    = 3'd1;  // reduce year mod 400 by repeated subtract
  localparam logic [2:0] StSetup  = 3'd2;  // sum the months before the start month
  localparam logic [2:0] StWalk   = 3'd3;  // walk months from january
  localparam logic [2:0] StFinish = 3'd4;  // hand the result to the output register

  logic [2:0] state_q, state_d;

  // working registers
  logic [gda_pkg::RemW-1:0]  rem_q, rem_d;
  logic [gda_pkg::YearW-1:0] year_q, year_d;
  logic [gda_pkg::YearW-1:0] ymod_q, ymod_d;   // full width during the reduction
  logic [3:0]                smon_q, smon_d;   // start month, clamped
  logic [3:0]                mon_q, mon_d;     // setup index, then walk month

  // output register
  logic        out_valid_q, out_valid_d;
  logic [4:0]  res_day_q, res_day_d;
  logic [3:0]  res_mon_q, res_mon_d;
  logic [13:0] res_year_q, res_year_d;
  logic        res_ovf_q, res_ovf_d;

  gda_pkg::alu_req_t alu_req;
  gda_pkg::alu_rsp_t alu_rsp;

  logic                       leap;
  logic [4:0]                 cur_len;
  logic [gda_pkg::ModW-1:0]   ymod_low;
  logic                       accept;
  logic                       out_free;
  logic                       ovf;

  gda_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign accept   = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;
  assign ymod_low = ymod_q[gda_pkg::ModW-1:0];
  assign leap     = gda_pkg::is_leap(ymod_low);
  assign cur_len  = gda_pkg::month_len(mon_q, leap);
  assign ovf      = (year_q > gda_pkg::YearMax);

  // operand selection for the shared alu
  always_comb begin
    alu_req.op = gda_pkg::AluSub;
    alu_req.a  = rem_q;
    alu_req.b  = {{(gda_pkg::RemW-5){1'b0}}, cur_len};
    case (state_q)
      StMod: begin
        alu_req.a = {{(gda_pkg::RemW-gda_pkg::YearW){1'b0}}, ymod_q};
        alu_req.b = gda_pkg::YearCycle;
      end
      StSetup: begin
        alu_req.op = gda_pkg::AluAdd;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    year_d      = year_q;
    ymod_d      = ymod_q;
    smon_d      = smon_q;
    mon_d       = mon_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_day_d   = res_day_q;
    res_mon_d   = res_mon_q;
    res_year_d  = res_year_q;
    res_ovf_d   = res_ovf_q;

    case (state_q)
      StIdle: begin
        if (accept) begin
          // zero day, zero month and zero year fold to one; months past december to 12
          rem_d = {{(gda_pkg::RemW-5){1'b0}}, (start_day_i == '0) ? 5'd1 : start_day_i}
                + {1'b0, days_to_add_i};
          if (start_month_i == '0) begin
            smon_d = gda_pkg::MonJan;
          end else if (start_month_i > gda_pkg::MonDec) begin
            smon_d = gda_pkg::MonDec;
          end else begin
            smon_d = start_month_i;
          end
          year_d  = {1'b0, (start_year_i == '0) ? 14'd1 : start_year_i};
          ymod_d  = year_d;
          state_d = StMod;
        end
      end
      StMod: begin
        if (alu_rsp.ge) begin
          ymod_d = alu_rsp.res[gda_pkg::YearW-1:0];
        end else begin
          mon_d   = gda_pkg::MonJan;
          state_d = StSetup;
        end
      end
      StSetup: begin
        if (mon_q < smon_q) begin
          rem_d = alu_rsp.res;
          mon_d = mon_q + 4'd1;
        end else begin
          mon_d   = gda_pkg::MonJan;
          state_d = StWalk;
        end
      end
      StWalk: begin
        if (alu_rsp.le) begin
          state_d = StFinish;
        end else begin
          rem_d = alu_rsp.res;
          if (mon_q == gda_pkg::MonDec) begin
            // roll over into january of the next year
            mon_d  = gda_pkg::MonJan;
            year_d = year_q + 15'd1;
            if (ymod_low == gda_pkg::ModLast) begin
              ymod_d = '0;
            end else begin
              ymod_d = ymod_q + 15'd1;
            end
          end else begin
            mon_d = mon_q + 4'd1;
          end
        end
      end
      StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_ovf_d   = ovf;
          // saturate to the last day of year 9999
          res_day_d   = ovf ? 5'd31 : rem_q[4:0];
          res_mon_d   = ovf ? gda_pkg::MonDec : mon_q;
          res_year_d  = ovf ? gda_pkg::YearMax[13:0] : year_q[13:0];
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    year_q     <= year_d;
    ymod_q     <= ymod_d;
    smon_q     <= smon_d;
    mon_q      <= mon_d;
    res_day_q  <= res_day_d;
    res_mon_q  <= res_mon_d;
    res_year_q <= res_year_d;
    res_ovf_q  <= res_ovf_d;
  end

  assign in_stall_o      = (state_q != StIdle);
  assign out_valid_o     = out_valid_q;
  assign result_day_o    = res_day_q;
  assign result_month_o  = res_mon_q;
  assign result_year_o   = res_year_q;
  assign year_overflow_o = res_ovf_q;

endmodule

[hdl/gda_alu.sv]
// shared add / subtract and compare unit of the gregorian date adder
module gda_alu (
  input  gda_pkg::alu_req_t req_i,
  output gda_pkg::alu_rsp_t rsp_o
);

  logic [gda_pkg::RemW:0] sum;

  always_comb begin
    if (req_i.op == gda_pkg::AluAdd) begin
      sum = {1'b0, req_i.a} + {1'b0, req_i.b};
    end else begin
      sum = {1'b0, req_i.a} - {1'b0, req_i.b};
    end
    rsp_o.res = sum[gda_pkg::RemW-1:0];
    // borrow out means a < b
    rsp_o.ge  = !sum[gda_pkg::RemW];
    rsp_o.le  = sum[gda_pkg::RemW] || (sum[gda_pkg::RemW-1:0] == '0);
  end

endmodule

[tb/gregorian_date_add_days_core_test.sv]
// self-checking testbench of the gregorian date adder: table-driven and random beats
module gregorian_date_add_days_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // run shape
  localparam int NumDirected = 22;
  localparam int NumRandom   = 520;
  localparam int CalmTail    = 60;     // last beats go without any idling
  localparam int HoldAtBeat  = 200;    // random beat that triggers the long output hold
  localparam int DrainAtBeat = 350;    // random beat before which the sender waits for drain
  localparam int HoldCycles  = 3000;   // long output hold, so the input side backs up
  localparam int TailCycles  = 1200;   // idle tail after the final drain
  localparam int CycleLimit  = 4000000;
  localparam int MaxReports  = 40;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        ovf;
  } date_out_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [14:0] add;
    logic        fixed;    // 1: expected result typed in below, 0: from the predictor
    date_out_t   want;
  } date_row_t;

  // directed beats: extremes, clamped inputs, leap rules, overflow
  localparam date_row_t Directed [NumDirected] = '{
    '{5'd1,  4'd1,  14'd1,     15'd0,     1'b1, '{5'd1,  4'd1,  14'd1,    1'b0}},
    '{5'd31, 4'd12, 14'd9999,  15'd0,     1'b1, '{5'd31, 4'd12, 14'd9999, 1'b0}},
    '{5'd31, 4'd12, 14'd9999,  15'd1,     1'b1, '{5'd31, 4'd12, 14'd9999, 1'b1}},
    '{5'd1,  4'd1,  14'd16383, 15'd0,     1'b1, '{5'd31, 4'd12, 14'd9999, 1'b1}},
    '{5'd31, 4'd15, 14'd16383, 15'd32767, 1'b1, '{5'd31, 4'd12, 14'd9999, 1'b1}},
    '{5'd0,  4'd0,  14'd0,     15'd0,     1'b1, '{5'd1,  4'd1,  14'd1,    1'b0}},
    '{5'd0,  4'd1,  14'd1,     15'd1,     1'b1, '{5'd2,  4'd1,  14'd1,    1'b0}},
    '{5'd1,  4'd0,  14'd2000,  15'd0,     1'b1, '{5'd1,  4'd1,  14'd2000, 1'b0}},
    '{5'd31, 4'd13, 14'd2001,  15'd0,     1'b1, '{5'd31, 4'd12, 14'd2001, 1'b0}},
    '{5'd31, 4'd15, 14'd9999,  15'd0,     1'b1, '{5'd31, 4'd12, 14'd9999, 1'b0}},
    '{5'd31, 4'd12, 14'd9998,  15'd1,     1'b1, '{5'd1,  4'd1,  14'd9999, 1'b0}},
    '{5'd15, 4'd15, 14'd2001,  15'd17,    1'b0, '0},
    '{5'd31, 4'd2,  14'd2023,  15'd0,     1'b0, '0},
    '{5'd30, 4'd2,  14'd2024,  15'd0,     1'b0, '0},
    '{5'd28, 4'd2,  14'd2000,  15'd1,     1'b0, '0},
    '{5'd28, 4'd2,  14'd1900,  15'd1,     1'b0, '0},
    '{5'd28, 4'd2,  14'd2024,  15'd1,     1'b0, '0},
    '{5'd29, 4'd2,  14'd2100,  15'd0,     1'b0, '0},
    '{5'd31, 4'd4,  14'd1999,  15'd3,     1'b0, '0},
    '{5'd1,  4'd1,  14'd1,     15'd32767, 1'b0, '0},
    '{5'd1,  4'd1,  14'd9910,  15'd32767, 1'b0, '0},
    '{5'd16, 4'd8,  14'd1234,  15'd12345, 1'b0, '0}
  };

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [4:0]  start_day_i     = '0;
  logic [3:0]  start_month_i   = '0;
  logic [13:0] start_year_i    = '0;
  logic [14:0] days_to_add_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [4:0]  result_day_o;
  logic [3:0]  result_month_o;
  logic [13:0] result_year_o;
  logic        year_overflow_o;

  date_out_t   expected_dates [$];   // results still owed by the block, oldest first
  int          mismatch_count = 0;
  int          cycle_count    = 0;
  bit          calm           = 1'b0; // tail of the run: no idling on either side
  bit          hold_req       = 1'b0; // asks the receiver for its long hold

  gregorian_date_add_days_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_day_i    (start_day_i),
    .start_month_i  (start_month_i),
    .start_year_i   (start_year_i),
    .days_to_add_i  (days_to_add_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_day_o   (result_day_o),
    .result_month_o (result_month_o),
    .result_year_o  (result_year_o),
    .year_overflow_o(year_overflow_o)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // month length with the full gregorian leap rule, month in 1..12
  function automatic int unsigned days_in_month(input int unsigned yr, input int unsigned mon);
    bit leap;
    leap = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
    if (mon == gda_pkg::MonFeb) return leap ? 29 : 28;
    if (mon inside {4, 6, 9, 11}) return 30;
    return 31;
  endfunction

  // date that lies add days after the start date, saturated past year 9999
  function automatic date_out_t advance_date(input logic [4:0] d, input logic [3:0] m,
                                             input logic [13:0] y, input logic [14:0] add);
    int unsigned day_cnt;
    int unsigned mon;
    int unsigned yr;
    int unsigned k;
    date_out_t   res;
    // out-of-range start fields are clamped, a day past month end just runs on
    day_cnt = (d == 0) ? 1 : d;
    mon     = (m == 0) ? 1 : ((m > gda_pkg::MonDec) ? gda_pkg::MonDec : m);
    yr      = (y == 0) ? 1 : y;
    // day of year, then the days to add on top
    for (k = gda_pkg::MonJan; k < mon; k++) day_cnt += days_in_month(yr, k);
    day_cnt += add;
    // walk from january, rolling into the next year after december
    mon = gda_pkg::MonJan;
    while (day_cnt > days_in_month(yr, mon)) begin
      day_cnt -= days_in_month(yr, mon);
      mon++;
      if (mon > gda_pkg::MonDec) begin
        mon = gda_pkg::MonJan;
        yr++;
      end
    end
    if (yr > 9999) begin
      res = '{5'd31, gda_pkg::MonDec, 14'd9999, 1'b1};
    end else begin
      res = '{day_cnt[4:0], mon[3:0], yr[13:0], 1'b0};
    end
    return res;
  endfunction

  // one beat on the input channel; payload and valid hold until accepted
  task automatic offer_beat(input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
                            input logic [14:0] add, input bit fixed, input date_out_t want);
    // optional idle burst before raising valid
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    start_day_i   <= d;
    start_month_i <= m;
    start_year_i  <= y;
    days_to_add_i <= add;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_dates.push_back(fixed ? want : advance_date(d, m, y, add));
  endtask

  // sender goes quiet until every owed result has come out
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_dates.size() != 0);
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MaxReports)
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  // output monitor: every accepted beat against the oldest expectation
  always @(posedge clk_i) begin
    date_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_dates.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("%0t: result beat expected none actual %0d-%0d-%0d ovf %0d", $time,
                   result_year_o, result_month_o, result_day_o, year_overflow_o);
      end else begin
        want = expected_dates.pop_front();
        compare_field("result_day",    want.day,   result_day_o);
        compare_field("result_month",  want.month, result_month_o);
        compare_field("result_year",   want.year,  result_year_o);
        compare_field("year_overflow", want.ovf,   year_overflow_o);
      end
    end
  end

  // receiver stall pattern: modes of no, light and heavy idling, re-picked now and then,
  // plus one long hold so the block fills up and stalls its input
  initial begin
    int  mode;
    int  mode_age;
    bit  hold_done;
    mode      = 0;
    mode_age  = 0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      mode_age++;
      if (mode_age >= 64) begin
        mode     = $urandom_range(0, 2);
        mode_age = 0;
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && mode != 0 &&
                   $urandom_range(0, (mode == 1) ? 7 : 1) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // stimulus
  initial begin
    int          idx;
    int unsigned pick;
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;
    logic [14:0] add;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (idx = 0; idx < NumDirected; idx++)
      offer_beat(Directed[idx].day, Directed[idx].month, Directed[idx].year,
                 Directed[idx].add, Directed[idx].fixed, Directed[idx].want);
    wait_for_drain();

    // random beats: mostly valid dates, some raw noise in every field
    for (idx = 0; idx < NumRandom; idx++) begin
      calm = (idx >= NumRandom - CalmTail);
      if (idx == HoldAtBeat) hold_req = 1'b1;
      if (idx == DrainAtBeat) wait_for_drain();

      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        y = 14'($urandom_range(0, 16383));
      end else if (pick == 1) begin
        y = 14'($urandom_range(9900, 9999));     // close to the overflow boundary
      end else if (pick == 2) begin
        y = 14'(100 * $urandom_range(15, 25));   // century years, leap or not
      end else begin
        y = 14'($urandom_range(1, 9999));
      end

      if ($urandom_range(0, 9) == 0) begin
        // noise: clamped months, day zero, day past month end
        d = 5'($urandom_range(0, 31));
        m = 4'($urandom_range(0, 15));
      end else begin
        m = 4'($urandom_range(gda_pkg::MonJan, gda_pkg::MonDec));
        d = 5'($urandom_range(1, days_in_month((y == 0) ? 1 : y, m)));
      end

      // most counts short so the month walk stays cheap, some over the full range
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        add = 15'($urandom_range(0, 400));
      end else if (pick < 8) begin
        add = 15'($urandom_range(0, 4000));
      end else begin
        add = 15'($urandom_range(0, 32767));
      end

      offer_beat(d, m, y, add, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_dates.size() != 0);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[gregorian_date_add_days_core.f]
hdl/gda_pkg.sv
hdl/gda_alu.sv
hdl/gregorian_date_add_days_core.sv
tb/gregorian_date_add_days_core_test.sv
